// ===== rtl/vad_pkg.sv =====
// Shared types and the normalized-integer to float32 conversion for the
// vertex attribute dequantizer. No dependencies.
package vad_pkg;

  typedef enum logic [1:0] {
    MODE_VEC3  = 2'd0,
    MODE_VEC2  = 2'd1,
    MODE_INDEX = 2'd2,
    MODE_NONE  = 2'd3
  } read_mode_t;

  typedef enum logic [2:0] {
    TYPE_BYTE   = 3'd0,
    TYPE_UBYTE  = 3'd1,
    TYPE_SHORT  = 3'd2,
    TYPE_USHORT = 3'd3,
    TYPE_UINT   = 3'd4,
    TYPE_FLOAT  = 3'd5,
    TYPE_RSV6   = 3'd6,
    TYPE_RSV7   = 3'd7
  } comp_type_t;

  typedef enum logic [0:0] {
    CFG_READ_MODE = 1'd0,
    CFG_COMP_TYPE = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_ZERO    = 3'd0,
    KIND_RAW     = 3'd1,
    KIND_SNORM8  = 3'd2,
    KIND_UNORM8  = 3'd3,
    KIND_SNORM16 = 3'd4,
    KIND_UNORM16 = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t [2:0]       kind;
    logic  [2:0][31:0] raw;
    logic  [31:0]      index;
  } vad_item_t;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] index_value;
  } vad_result_t;

  localparam logic [31:0] FP_ONE = 32'h3F80_0000;

  // m / (2^k - 1) for 0 < m < 2^k - 1 is the k-bit pattern of m repeating
  // forever; the tail is never zero, so rounding is a plain round-half-up
  // with sticky set, and a tie cannot occur.
  function automatic logic [31:0] to_float(input kind_t kind, input logic [31:0] raw);
    logic        sg;
    logic [15:0] m;
    logic [15:0] d;
    logic [15:0] ma;
    logic [47:0] w;
    logic [47:0] s;
    logic [3:0]  lz;
    logic [24:0] mant;
    logic [7:0]  ex;
    logic        found;
    sg = 1'b0;
    m  = '0;
    d  = 16'd1;
    ma = '0;
    w  = '0;
    case (kind)
      KIND_SNORM8: begin
        sg = raw[7];
        m  = {8'd0, raw[7] ? (8'd0 - raw[7:0]) : raw[7:0]};
        d  = 16'd127;
        ma = {m[6:0], 9'd0};
        w  = 48'({7{m[6:0]}} >> 1);
      end
      KIND_UNORM8: begin
        m  = {8'd0, raw[7:0]};
        d  = 16'd255;
        ma = {m[7:0], 8'd0};
        w  = {6{m[7:0]}};
      end
      KIND_SNORM16: begin
        sg = raw[15];
        m  = raw[15] ? (16'd0 - raw[15:0]) : raw[15:0];
        d  = 16'd32767;
        ma = {m[14:0], 1'b0};
        w  = 48'({4{m[14:0]}} >> 12);
      end
      KIND_UNORM16: begin
        m  = raw[15:0];
        d  = 16'd65535;
        ma = m;
        w  = {3{m}};
      end
      default: begin
      end
    endcase
    lz    = '0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found && ma[i]) begin
        found = 1'b1;
        lz    = 4'(15 - i);
      end
    end
    s    = w << lz;
    mant = {1'b0, s[47:24]} + {24'd0, s[23]};
    ex   = 8'd126 - {4'd0, lz};
    if (mant[24]) begin
      ex = ex + 8'd1;
    end
    case (kind)
      KIND_ZERO: to_float = '0;
      KIND_RAW:  to_float = raw;
      default: begin
        if (m == 16'd0 || (kind == KIND_SNORM16 && m[15])) begin
          // zero, or the most negative short which clamps to -1
          to_float = (m == 16'd0) ? 32'd0 : {1'b1, FP_ONE[30:0]};
        end else if (m >= d) begin
          to_float = {sg, FP_ONE[30:0]};
        end else begin
          to_float = {sg, ex, mant[24] ? 23'd0 : mant[22:0]};
        end
      end
    endcase
  endfunction

endpackage

// ===== rtl/vad_front.sv =====
// Front end: configuration registers, element capture and classification,
// and a two-entry queue toward the back end. Depends on vad_pkg.
module vad_front import vad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_element_bytes_low,
  input  logic [31:0] in_element_bytes_high,
  output logic        item_valid,
  input  logic        item_take,
  output vad_item_t   item
);

  read_mode_t mode_r;
  comp_type_t ctype_r;
  vad_item_t  q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  vad_item_t  cls;
  logic [95:0] eb;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_VEC3;
      ctype_r <= TYPE_FLOAT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_READ_MODE: mode_r  <= read_mode_t'(cfg_data[1:0]);
        CFG_COMP_TYPE: ctype_r <= comp_type_t'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  assign eb = {in_element_bytes_high, in_element_bytes_low};

  always_comb begin
    kind_t k;
    cls = '0;
    case (ctype_r)
      TYPE_BYTE:   k = KIND_SNORM8;
      TYPE_UBYTE:  k = KIND_UNORM8;
      TYPE_SHORT:  k = KIND_SNORM16;
      TYPE_USHORT: k = KIND_UNORM16;
      default:     k = KIND_RAW;
    endcase
    for (int c = 0; c < 3; c++) begin
      case (ctype_r)
        TYPE_BYTE, TYPE_UBYTE:    cls.raw[c] = {24'd0, eb[8*c +: 8]};
        TYPE_SHORT, TYPE_USHORT:  cls.raw[c] = {16'd0, eb[16*c +: 16]};
        default:                  cls.raw[c] = eb[32*c +: 32];
      endcase
    end
    case (mode_r)
      MODE_VEC3: begin
        cls.kind[0] = k;
        cls.kind[1] = k;
        cls.kind[2] = k;
      end
      MODE_VEC2: begin
        cls.kind[0] = k;
        cls.kind[1] = k;
        cls.kind[2] = KIND_ZERO;
      end
      MODE_INDEX: begin
        cls.kind[0] = KIND_ZERO;
        cls.kind[1] = KIND_ZERO;
        cls.kind[2] = KIND_ZERO;
        case (ctype_r)
          TYPE_UBYTE:  cls.index = {24'd0, eb[7:0]};
          TYPE_USHORT: cls.index = {16'd0, eb[15:0]};
          default:     cls.index = eb[31:0];
        endcase
      end
      default: begin
        cls.kind[0] = KIND_ZERO;
        cls.kind[1] = KIND_ZERO;
        cls.kind[2] = KIND_ZERO;
      end
    endcase
  end

  assign in_full    = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign push       = in_push && !in_full;
  assign pop        = item_take && item_valid;
  assign item       = q_r[rd_ptr_r];
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== rtl/vad_back.sv =====
// Back end: converts queued items to float32 (or raw) results and holds them in a
// two-entry result queue. Depends on vad_pkg.
module vad_back import vad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  output logic        item_take,
  input  vad_item_t   item,
  output logic        out_empty,
  input  logic        pop,
  output vad_result_t res
);

  vad_result_t q_r [2];
  vad_result_t conv;
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        deq;

  always_comb begin
    conv.comp_x      = to_float(item.kind[0], item.raw[0]);
    conv.comp_y      = to_float(item.kind[1], item.raw[1]);
    conv.comp_z      = to_float(item.kind[2], item.raw[2]);
    conv.index_value = item.index;
  end

  assign item_take = item_valid && (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign deq       = pop && !out_empty;
  assign res       = q_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + {1'b0, item_take} - {1'b0, deq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (item_take) wr_ptr_r <= !wr_ptr_r;
      if (deq)       rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) q_r[wr_ptr_r] <= conv;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("result queue pointers disagree with count");
  a_take_grows: assert property (@(posedge clk) disable iff (!rst_n)
      (item_take && !deq) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("result queue lost an item");

endmodule

// ===== rtl/vertex_attribute_dequantizer.sv =====
// Vertex attribute dequantizer: decodes one 12-byte little-endian element per
// cycle, while in_full is low, into up to three float32 or raw 32-bit
// components or one widened index. A pushed element is held in the front
// queue, converted as the back end takes it into the result queue, and
// then shows on the result ports, where it can be popped; with pop held
// high the block sustains one element per clock. Write configuration only
// while idle. Depends on vad_pkg, vad_front and vad_back.
module vertex_attribute_dequantizer import vad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_element_bytes_low,
  input  logic [31:0] in_element_bytes_high,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_comp_x,
  output logic [31:0] out_comp_y,
  output logic [31:0] out_comp_z,
  output logic [31:0] out_index_value
);

  logic        item_valid, item_take;
  vad_item_t   item;
  vad_result_t res;

  vad_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_full, .in_element_bytes_low, .in_element_bytes_high,
    .item_valid, .item_take, .item
  );

  vad_back u_back (
    .clk, .rst_n, .item_valid, .item_take, .item,
    .out_empty, .pop(out_pop), .res
  );

  assign out_comp_x      = res.comp_x;
  assign out_comp_y      = res.comp_y;
  assign out_comp_z      = res.comp_z;
  assign out_index_value = res.index_value;

endmodule
